// ===== src/ldf_pkg.sv =====
// Shared types and constants of the LED display update formatter.
package ldf_pkg;

  // Display controller register addresses
  localparam logic [3:0] REG_DECODE = 4'd9;
  localparam logic [3:0] REG_DIGIT0 = 4'd1;
  localparam logic [3:0] REG_DIGIT1 = 4'd2;
  localparam logic [3:0] REG_DIGIT2 = 4'd3;
  localparam logic [3:0] REG_DIGIT3 = 4'd4;

  // Decode-mode masks
  localparam logic [7:0] DECODE_DIGITS = 8'h07;
  localparam logic [7:0] DECODE_NONE   = 8'h00;

  // Raw segment glyphs
  localparam logic [7:0] GLYPH_P     = 8'h67;
  localparam logic [7:0] GLYPH_C     = 8'h4E;
  localparam logic [7:0] GLYPH_A     = 8'h77;
  localparam logic [7:0] GLYPH_L     = 8'h0E;
  localparam logic [7:0] GLYPH_O     = 8'h7E;
  localparam logic [7:0] GLYPH_F     = 8'h47;
  localparam logic [7:0] GLYPH_BLANK = 8'h00;

  // Position of a write within one update
  typedef logic [2:0] ldf_slot_t;
  localparam ldf_slot_t SLOT_DECODE = 3'd0;
  localparam ldf_slot_t SLOT_D0     = 3'd1;
  localparam ldf_slot_t SLOT_D1     = 3'd2;
  localparam ldf_slot_t SLOT_D2     = 3'd3;
  localparam ldf_slot_t SLOT_D3     = 3'd4;

  // One queued update: decode mode plus the four digit bytes
  typedef struct packed {
    logic       bcd;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
  } ldf_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } ldf_q_stat_t;

endpackage

// ===== src/ldf_in_if.sv =====
// Input item channel: time, azimuths and mode flags.
interface ldf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [9:0]  azimuth;
  logic [9:0]  preset_azimuth;
  logic        show_preset;
  logic        ccw_cal;
  logic        cw_cal;

  modport source (
    output valid, now_ms, azimuth, preset_azimuth, show_preset, ccw_cal, cw_cal,
    input  ready
  );
  modport sink (
    input  valid, now_ms, azimuth, preset_azimuth, show_preset, ccw_cal, cw_cal,
    output ready
  );
endinterface

// ===== src/ldf_out_if.sv =====
// Output item channel: one display controller register write.
interface ldf_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_addr;
  logic [7:0] reg_data;
  logic       last_write;

  modport source (
    output valid, reg_addr, reg_data, last_write,
    input  ready
  );
  modport sink (
    input  valid, reg_addr, reg_data, last_write,
    output ready
  );
endinterface

// ===== src/ldf_front.sv =====
// Front end: interval gate, mode selection and BCD split into a queue entry.
module ldf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        interval_i,
  ldf_in_if.sink             in_i,
  input  ldf_pkg::ldf_q_stat_t q_stat_i,
  output logic               q_push_o,
  output ldf_pkg::ldf_entry_t q_data_o
);
  import ldf_pkg::*;

  logic [31:0] last_q, last_d;
  logic [31:0] elapsed;
  logic        accept;
  logic        due;
  logic [9:0]  value;
  logic [17:0] m10;
  logic [15:0] m100;
  logic [6:0]  q10;
  logic [3:0]  q100;
  logic [3:0]  hund;
  logic [6:0]  tens_w;
  logic [9:0]  ones_w;

  assign in_i.ready = ~q_stat_i.full;
  assign accept     = in_i.valid & in_i.ready;
  assign elapsed    = in_i.now_ms - last_q;
  assign due        = elapsed >= {16'd0, interval_i};
  assign q_push_o   = accept & due;
  assign last_d     = q_push_o ? in_i.now_ms : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 32'd0;
    end else begin
      last_q <= last_d;
    end
  end

  // Reciprocal division: x*205>>11 = x/10 and x*41>>12 = x/100 for x below 1024
  assign value  = in_i.show_preset ? in_i.preset_azimuth : in_i.azimuth;
  assign m10    = 18'(value) * 18'd205;
  assign m100   = 16'(value) * 16'd41;
  assign q10    = m10[17:11];
  assign q100   = m100[15:12];
  assign hund   = (q100 >= 4'd10) ? q100 - 4'd10 : q100;
  assign tens_w = q10 - 7'(q100) * 7'd10;
  assign ones_w = value - 10'(q10) * 10'd10;

  always_comb begin
    q_data_o.bcd = 1'b1;
    q_data_o.d0  = {4'd0, hund};
    q_data_o.d1  = {4'd0, tens_w[3:0]};
    q_data_o.d2  = {4'd0, ones_w[3:0]};
    q_data_o.d3  = GLYPH_BLANK;
    if (in_i.show_preset) begin
      q_data_o.d3 = GLYPH_P;
    end else if (in_i.ccw_cal || in_i.cw_cal) begin
      q_data_o.bcd = 1'b0;
      q_data_o.d0  = GLYPH_C;
      q_data_o.d1  = GLYPH_A;
      q_data_o.d2  = GLYPH_L;
      q_data_o.d3  = in_i.ccw_cal ? GLYPH_O : GLYPH_F;
    end
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_stat_i.full)
    else $error("front pushed into a full queue");

  a_time_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |=> last_q == $past(in_i.now_ms))
    else $error("update time not stored");

  a_gate_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !due) |=> $stable(last_q))
    else $error("update time changed on a gated item");

endmodule

// ===== src/ldf_fifo.sv =====
// Short queue of pending updates between front and back.
module ldf_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ldf_pkg::ldf_entry_t  data_i,
  input  logic                 pop_i,
  output ldf_pkg::ldf_entry_t  data_o,
  output ldf_pkg::ldf_q_stat_t stat_o
);
  import ldf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  ldf_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign stat_o.full  = cnt_q == CntW'(Depth);
  assign stat_o.empty = cnt_q == '0;
  assign data_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue underflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

// ===== src/ldf_back.sv =====
// Back end: walks a queued update out as five register writes.
module ldf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ldf_pkg::ldf_q_stat_t q_stat_i,
  input  ldf_pkg::ldf_entry_t  q_data_i,
  output logic                 q_pop_o,
  ldf_out_if.source            out_o
);
  import ldf_pkg::*;

  ldf_slot_t  slot_q, slot_d;
  logic       valid_q, valid_d;
  logic [3:0] addr_q, addr_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic       load;
  logic       emit;

  // Output register frees when empty or being taken
  assign load    = ~valid_q | out_o.ready;
  assign emit    = load & ~q_stat_i.empty;
  assign q_pop_o = emit & (slot_q == SLOT_D3);

  always_comb begin
    addr_d = REG_DECODE;
    data_d = DECODE_NONE;
    last_d = 1'b0;
    unique case (slot_q)
      SLOT_DECODE: begin
        addr_d = REG_DECODE;
        data_d = q_data_i.bcd ? DECODE_DIGITS : DECODE_NONE;
      end
      SLOT_D0: begin
        addr_d = REG_DIGIT0;
        data_d = q_data_i.d0;
      end
      SLOT_D1: begin
        addr_d = REG_DIGIT1;
        data_d = q_data_i.d1;
      end
      SLOT_D2: begin
        addr_d = REG_DIGIT2;
        data_d = q_data_i.d2;
      end
      SLOT_D3: begin
        addr_d = REG_DIGIT3;
        data_d = q_data_i.d3;
        last_d = 1'b1;
      end
      default: begin
        addr_d = REG_DECODE;
        data_d = DECODE_NONE;
      end
    endcase
  end

  always_comb begin
    slot_d = slot_q;
    if (emit) begin
      slot_d = (slot_q == SLOT_D3) ? SLOT_DECODE : slot_q + 1'b1;
    end
  end

  assign valid_d = emit | (valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SLOT_DECODE;
      valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.reg_addr   = addr_q;
  assign out_o.reg_data   = data_q;
  assign out_o.last_write = last_q;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_D3)
    else $error("write slot out of range");

  a_last_is_digit3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> addr_q == REG_DIGIT3)
    else $error("last write flagged on wrong register");

  a_update_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && slot_q == SLOT_DECODE) |=> (valid_q && addr_q == REG_DECODE))
    else $error("update did not open with decode-mode write");

endmodule

// ===== src/led_display_update_formatter.sv =====
// Top level of the LED display update formatter: config register and front/queue/back.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------------
//   in_i    | in  | valid/ready        | now_ms, azimuth, preset_azimuth, flags
//   out_o   | out | valid/ready        | reg_addr, reg_data, last_write
//   apb     | in  | psel/penable/pready| paddr[2:0], pwdata -> update_interval_ms
//
// An item is taken every cycle while the queue has room; a gated item leaves no trace.
// An item that is due produces five writes, one per cycle from the back end's
// output register while out_o is ready.
// Reset: interval 250 ms, last update time 0, queue and output empty.
// The input stalls only when the queue is full; the output stalls hold the write shown.
module led_display_update_formatter #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ldf_in_if.sink      in_i,
  ldf_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ldf_pkg::*;

  localparam logic       REG_IDX_INTERVAL = 1'b0;
  localparam logic [15:0] INTERVAL_RESET  = 16'd250;

  logic [15:0]  interval_q, interval_d;
  logic         cfg_wr;
  logic         q_push;
  logic         q_pop;
  ldf_entry_t   q_wdata;
  ldf_entry_t   q_rdata;
  ldf_q_stat_t  q_stat;

  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite & pready;
  assign interval_d = (cfg_wr && paddr[2] == REG_IDX_INTERVAL) ? pwdata[15:0] : interval_q;
  assign prdata     = (paddr[2] == REG_IDX_INTERVAL) ? {16'd0, interval_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
    end else begin
      interval_q <= interval_d;
    end
  end

  ldf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .interval_i (interval_q),
    .in_i       (in_i),
    .q_stat_i   (q_stat),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  ldf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  ldf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for led_display_update_formatter: directed rows, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import ldf_pkg::*;

  localparam int unsigned SETTLE_CYC    = 16;
  localparam int unsigned HOLD_CYC      = 120;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned PHASE_ITEMS   = 25;
  localparam logic [2:0]  ADDR_INTERVAL = 3'd0;
  localparam logic [15:0] INTERVAL_RST  = 16'd250;

  // Five data bytes of one refresh, decode-mode write first
  localparam logic [39:0] TXT_NONE = 40'd0;
  localparam logic [39:0] TXT_CALO = {DECODE_NONE, GLYPH_C, GLYPH_A, GLYPH_L, GLYPH_O};
  localparam logic [39:0] TXT_CALF = {DECODE_NONE, GLYPH_C, GLYPH_A, GLYPH_L, GLYPH_F};
  localparam logic [19:0] SLOT_ADDRS = {REG_DECODE, REG_DIGIT0, REG_DIGIT1, REG_DIGIT2,
                                        REG_DIGIT3};

  typedef struct packed {
    logic [31:0] now_ms;
    logic [9:0]  azimuth;
    logic [9:0]  preset_azimuth;
    logic        show_preset;
    logic        ccw_cal;
    logic        cw_cal;
  } upd_req_t;

  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
    logic       last_write;
  } disp_write_t;

  // ROW_TYPED/ROW_QUIET carry their own expectation, ROW_PRED goes through the predictor,
  // ROW_CFG writes the interval held in now_ms
  typedef enum logic [1:0] {ROW_PRED, ROW_QUIET, ROW_TYPED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    upd_req_t    req;
    logic [39:0] bytes;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ldf_in_if  in_if ();
  ldf_out_if out_if ();

  led_display_update_formatter i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  logic [15:0]  interval_q;
  logic [31:0]  last_upd_q;
  disp_write_t  pending_writes [$];

  int unsigned n_errors  = 0;
  int unsigned n_items   = 0;
  int unsigned n_refresh = 0;
  int unsigned n_writes  = 0;
  int unsigned n_holds   = 0;
  int unsigned quiet_cyc = 0;
  bit          no_gaps   = 1'b0;
  bit          hold_out  = 1'b0;

  dir_row_t dir_tab [24] = '{
    '{ROW_QUIET, '{32'd0,    10'd5,    10'd7,    1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_QUIET, '{32'd249,  10'd999,  10'd0,    1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_TYPED, '{32'd250,  10'd0,    10'd999,  1'b0, 1'b0, 1'b0},
      {DECODE_DIGITS, 8'd0, 8'd0, 8'd0, GLYPH_BLANK}},
    '{ROW_QUIET, '{32'd499,  10'd999,  10'd0,    1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_TYPED, '{32'd500,  10'd999,  10'd0,    1'b0, 1'b0, 1'b0},
      {DECODE_DIGITS, 8'd9, 8'd9, 8'd9, GLYPH_BLANK}},
    '{ROW_TYPED, '{32'd750,  10'd0,    10'd1023, 1'b1, 1'b0, 1'b0},
      {DECODE_DIGITS, 8'd0, 8'd2, 8'd3, GLYPH_P}},
    '{ROW_TYPED, '{32'd1000, 10'd123,  10'd0,    1'b0, 1'b1, 1'b1}, TXT_CALO},
    '{ROW_TYPED, '{32'd1250, 10'd123,  10'd0,    1'b0, 1'b0, 1'b1}, TXT_CALF},
    '{ROW_TYPED, '{32'd1500, 10'd1023, 10'd0,    1'b1, 1'b1, 1'b1},
      {DECODE_DIGITS, 8'd0, 8'd0, 8'd0, GLYPH_P}},
    '{ROW_TYPED, '{32'd1750, 10'd1023, 10'd0,    1'b0, 1'b0, 1'b0},
      {DECODE_DIGITS, 8'd0, 8'd2, 8'd3, GLYPH_BLANK}},
    '{ROW_PRED,  '{32'd2000, 10'd0,    10'd999,  1'b0, 1'b1, 1'b0}, TXT_NONE},
    '{ROW_PRED,  '{32'd2250, 10'd512,  10'd341,  1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_PRED,  '{32'd2500, 10'd341,  10'd682,  1'b1, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_PRED,  '{32'hFFFF_FF00, 10'd682, 10'd512, 1'b0, 1'b0, 1'b0}, TXT_NONE},
    // time wrapped: difference is 0x110
    '{ROW_PRED,  '{32'h0000_0010, 10'd1, 10'd1, 1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_QUIET, '{32'h0000_0100, 10'd2, 10'd2, 1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_CFG,   '{32'd0,     10'd0,   10'd0,    1'b0, 1'b0, 1'b0}, TXT_NONE},
    // zero interval: same time and a backwards step both refresh
    '{ROW_PRED,  '{32'h0000_0100, 10'd77, 10'd0, 1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_PRED,  '{32'h0000_0100, 10'd0, 10'd808, 1'b1, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_PRED,  '{32'd0,     10'd0,   10'd0,    1'b0, 1'b0, 1'b1}, TXT_NONE},
    '{ROW_CFG,   '{32'd65535, 10'd0,   10'd0,    1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_QUIET, '{32'd65534, 10'd0,   10'd0,    1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_PRED,  '{32'd65535, 10'd100, 10'd0,    1'b0, 1'b0, 1'b0}, TXT_NONE},
    '{ROW_PRED,  '{32'hFFFF_FFFF, 10'h2AA, 10'h155, 1'b0, 1'b1, 1'b0}, TXT_NONE}
  };

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [39:0] bcd_bytes(input logic [9:0] v, input logic [7:0] glyph);
    int unsigned n;
    n = v;
    return {DECODE_DIGITS, 8'((n / 100) % 10), 8'((n / 10) % 10), 8'(n % 10), glyph};
  endfunction

  // Returns 1 when the item is due a refresh; bytes then hold its five data bytes
  function automatic bit predict_refresh(input upd_req_t r, output logic [39:0] bytes);
    bytes = TXT_NONE;
    if (r.now_ms - last_upd_q < {16'd0, interval_q}) return 1'b0;
    last_upd_q = r.now_ms;
    if (r.show_preset)  bytes = bcd_bytes(r.preset_azimuth, GLYPH_P);
    else if (r.ccw_cal) bytes = TXT_CALO;
    else if (r.cw_cal)  bytes = TXT_CALF;
    else                bytes = bcd_bytes(r.azimuth, GLYPH_BLANK);
    return 1'b1;
  endfunction

  function automatic void queue_refresh(input logic [39:0] bytes);
    disp_write_t w;
    for (int k = 0; k < 5; k++) begin
      w.reg_addr   = SLOT_ADDRS[19 - 4 * k -: 4];
      w.reg_data   = bytes[39 - 8 * k -: 8];
      w.last_write = (k == int'(SLOT_D3));
      pending_writes.push_back(w);
    end
    n_refresh++;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Ends in the idle state so back-to-back transfers never toggle psel in one step
  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_interval_reg();
    logic [31:0] rd;
    apb_xfer(1'b0, ADDR_INTERVAL, 32'd0, rd);
    check_field("interval[15:8]", interval_q[15:8], rd[15:8]);
    check_field("interval[7:0]", interval_q[7:0], rd[7:0]);
  endtask

  // Only once the block is idle: gated items leave no result to wait for
  task automatic set_interval(input logic [15:0] v);
    logic [31:0] rd;
    in_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    apb_xfer(1'b1, ADDR_INTERVAL, {16'd0, v}, rd);
    interval_q = v;
    check_interval_reg();
  endtask

  // valid is left high on return; the next call drops it only when a gap follows
  task automatic offer(input upd_req_t r, input int unsigned gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.now_ms         <= r.now_ms;
    in_if.azimuth        <= r.azimuth;
    in_if.preset_azimuth <= r.preset_azimuth;
    in_if.show_preset    <= r.show_preset;
    in_if.ccw_cal        <= r.ccw_cal;
    in_if.cw_cal         <= r.cw_cal;
    do @(posedge clk_i); while (!in_if.ready);
    n_items++;
  endtask

  initial begin : sink_proc
    disp_write_t got;
    disp_write_t want;
    int unsigned gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        gap = HOLD_CYC;
        n_holds++;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got = '{out_if.reg_addr, out_if.reg_data, out_if.last_write};
      n_writes++;
      if (pending_writes.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected write, expected none, got addr %0d data %h last %b",
                 $time, got.reg_addr, got.reg_data, got.last_write);
      end else begin
        want = pending_writes.pop_front();
        check_field("reg_addr", {4'd0, want.reg_addr}, {4'd0, got.reg_addr});
        check_field("reg_data", want.reg_data, got.reg_data);
        check_field("last_write", {7'd0, want.last_write}, {7'd0, got.last_write});
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
        quiet_cyc <= 0;
      end else if (quiet_cyc >= STALL_LIMIT) begin
        $display("%0t: timeout, no handshake for %0d cycles, %0d writes outstanding",
                 $time, quiet_cyc, pending_writes.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
    end
  end

  initial begin : stim_proc
    dir_row_t    row;
    upd_req_t    req;
    logic [39:0] bytes;
    logic [31:0] t_now;
    int unsigned iv;
    int unsigned pick;
    bit          due;

    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.now_ms         = '0;
    in_if.azimuth        = '0;
    in_if.preset_azimuth = '0;
    in_if.show_preset    = 1'b0;
    in_if.ccw_cal        = 1'b0;
    in_if.cw_cal         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    interval_q           = INTERVAL_RST;
    last_upd_q           = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_interval_reg();

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        set_interval(row.req.now_ms[15:0]);
      end else begin
        offer(row.req, draw_gap());
        due = predict_refresh(row.req, bytes);
        case (row.kind)
          ROW_TYPED: queue_refresh(row.bytes);
          ROW_PRED: begin
            if (due) queue_refresh(bytes);
          end
          default: ;
        endcase
      end
    end

    // Phase 0 runs without idling and with one long output hold-off to fill the queue
    t_now = 32'h0001_0000;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       iv = $urandom_range(1, 1000);
        1:       iv = $urandom_range(0, 3);
        2:       iv = $urandom_range(40000, 65535);
        default: iv = $urandom_range(0, 65535);
      endcase
      set_interval(16'(iv));
      no_gaps  = (p == 0);
      hold_out = (p == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 4)      t_now = t_now + $urandom_range(0, iv);
        else if (pick < 9) t_now = t_now + iv + $urandom_range(0, 300);
        else               t_now = $urandom;
        req.now_ms         = t_now;
        req.azimuth        = 10'($urandom_range(0, 1023));
        req.preset_azimuth = 10'($urandom_range(0, 1023));
        req.show_preset    = ($urandom_range(0, 2) == 0);
        req.ccw_cal        = ($urandom_range(0, 2) == 0);
        req.cw_cal         = ($urandom_range(0, 2) == 0);
        offer(req, draw_gap());
        if (predict_refresh(req, bytes)) queue_refresh(bytes);
      end
    end
    no_gaps = 1'b0;

    in_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Run: %0d items, %0d refreshes, %0d register writes checked", n_items, n_refresh,
             n_writes);
    $display("Intervals 0 to 65535, time wrap, all display modes, %0d output hold-off(s)",
             n_holds);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
